// ===== hdl/bdh_pkg.sv =====
`default_nettype none
package bdh_pkg;
    localparam int SLOTS = 4096;
    localparam int AW = $clog2(SLOTS);
    localparam int KW = 24;
    localparam int VW = 32;
    localparam int SW = 12;
    localparam int LOAD_LIMIT = 95;
    localparam logic [31:0] HASH_MUL = 32'd3141;
    localparam int STEP_MOD = 37;
    // floor(k / 37) = (k * RECIP37) >> RECIP_SHIFT for every 24-bit k
    localparam logic [23:0] RECIP37 = 24'd14510025;
    localparam int RECIP_SHIFT = 29;
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_UPDATED = 2'd1;
    localparam logic [1:0] ST_FOUND = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;
    localparam logic REQ_SET = 1'b0;
    localparam logic REQ_GET = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_HASH, S_HMOD, S_STEP, S_SRD, S_SCHK, S_SADV,
        S_LOAD, S_IRD, S_ICHK, S_NRD, S_NCHK, S_CRD, S_CCHK, S_IADV,
        S_WRITE, S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0] status;
        logic [VW-1:0] value_out;
    } resp_t;
endpackage
`default_nettype wire

// ===== hdl/bdh_if.sv =====
`default_nettype none
interface bdh_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic [23:0] key;
    logic [31:0] value;
    modport source (output valid, req_type, key, value, input ready);
    modport sink (input valid, req_type, key, value, output ready);
endinterface

interface bdh_resp_if;
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [31:0] value_out;
    modport source (output valid, status, value_out, input ready);
    modport sink (input valid, status, value_out, output ready);
endinterface

interface bdh_cfg_if;
    logic valid;
    logic ready;
    logic [11:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bdh_mod.sv =====
`default_nettype none
// sequential remainder a mod m, one restoring step per cycle
module bdh_mod (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] num,
    input  wire logic [12:0] den,
    output logic             done,
    output logic [12:0]      rem
);
    import bdh_pkg::*;
    logic [31:0] num_reg, num_next;
    logic [13:0] rem_reg, rem_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [13:0] sh;

    always_comb
    begin
        sh = {rem_reg[12:0], num_reg[31]};
        num_next = num_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            num_next = num;
            rem_next = '0;
            cnt_next = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[30:0], 1'b0};
            rem_next = (sh >= {1'b0, den}) ? sh - {1'b0, den} : sh;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done = !busy_reg && !start;
    assign rem = rem_reg[12:0];
endmodule
`default_nettype wire

// ===== hdl/bdh_mem.sv =====
`default_nettype none
// slot store: key/value/valid, one port, registered read
module bdh_mem (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic                 vwe,
    input  wire logic [bdh_pkg::AW-1:0] addr,
    input  wire logic [bdh_pkg::KW-1:0] wkey,
    input  wire logic [bdh_pkg::VW-1:0] wval,
    input  wire logic                 wvalid,
    output logic [bdh_pkg::KW-1:0]    rkey,
    output logic [bdh_pkg::VW-1:0]    rval,
    output logic                      rvalid
);
    import bdh_pkg::*;
    logic [KW+VW-1:0] kv_mem [SLOTS];
    logic valid_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
            kv_mem[addr] <= {wkey, wval};
        {rkey, rval} <= kv_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (vwe)
            valid_mem[addr] <= wvalid;
        rvalid <= valid_mem[addr];
    end
endmodule
`default_nettype wire

// ===== hdl/brent_double_hash_table_top.sv =====
`default_nettype none
// open-addressed hash table, double hashing with brent insertion
// channels: req (req_type, key, value) in, resp (status, value_out) out,
//   cfg sets table_size; write it only while no request is in work
// one request is in work at a time; req.ready is high only when idle
// the home slot needs a serial remainder by the table size; the
//   probe step comes from a reciprocal multiply in the same window
// each search probe past the home slot adds a remainder to advance, a
//   read and a check; an insert walks again from home: a read and a
//   check for the free slot; each occupied slot passed, and one where
//   a brent move ends it, costs two remainders with reads for the next
//   slot and the blocker's next slot; the serial remainder and the
//   single memory port set the pace; a new request is taken the cycle
//   after the result transfer
// after reset a clearing pass zeroes the valid bits of all 4096 slots,
//   one slot a cycle; no request is taken until it ends, cfg writes
//   are taken
// the result waits in an output register; while the receiver stalls the
//   block holds it and takes no new request
module brent_double_hash_table_top (
    input  wire logic clk,
    input  wire logic rst_n,
    bdh_req_if.sink   req,
    bdh_resp_if.source resp,
    bdh_cfg_if.sink   cfg
);
    import bdh_pkg::*;

    state_t state_reg, state_next;
    logic [SW-1:0] tsize_reg;
    logic [12:0] cnt_reg;          // entry count
    logic [AW:0] clr_reg;
    logic          rtype_reg;
    logic [KW-1:0] key_reg;
    logic [VW-1:0] val_reg;
    logic [12:0]   s_eff;
    logic [AW-1:0] home_reg, i_reg, nxt_reg, col_reg;
    logic [5:0]    step_reg;       // 1..37
    logic [12:0]   nvis_reg;
    logic [KW-1:0] bkey_reg;
    logic [VW-1:0] bval_reg;
    logic [47:0]   mprod_reg;      // key times reciprocal of 37
    logic          out_valid_reg;
    resp_t         out_reg;

    // memory signals
    logic we, vwe, wvalid;
    logic [AW-1:0] addr;
    logic [KW-1:0] wkey, rkey;
    logic [VW-1:0] wval, rval;
    logic rvalid;

    // remainder unit
    logic m_start, m_done;
    logic [31:0] m_num;
    logic [12:0] m_den, m_rem;
    logic [31:0] prod;
    logic [31:0] mag;

    // 1 + k mod 37 from k and its reciprocal product
    function automatic logic [5:0] step_of(input logic [KW-1:0] k,
                                           input logic [47:0] p);
        logic [18:0] q;
        logic [KW:0] r;
        q = p[47:RECIP_SHIFT];
        r = {1'b0, k} - (25'(q) * 25'(STEP_MOD));
        return r[5:0] + 6'd1;
    endfunction

    bdh_mem u_mem (.clk, .we, .vwe, .addr, .wkey, .wval, .wvalid,
                   .rkey, .rval, .rvalid);
    bdh_mod u_mod (.clk, .rst_n, .start(m_start), .num(m_num), .den(m_den),
                   .done(m_done), .rem(m_rem));

    always_comb
    begin
        if ({1'b0, tsize_reg} > 13'(SLOTS))
            s_eff = 13'(SLOTS);
        else if (tsize_reg == '0)
            s_eff = 13'd1;
        else
            s_eff = {1'b0, tsize_reg};
    end

    assign prod = 32'(key_reg) * HASH_MUL;
    assign mag = prod[31] ? 32'(0) - prod : prod;
    logic [5:0] kstep;
    logic [13:0] adv_sum;
    logic [AW-1:0] adv_mod;
    logic [19:0] load_lhs;
    logic load_over;
    assign load_lhs = 20'(cnt_reg) * 20'd100;
    // 100*n/s > L  <=>  100*n >= (L+1)*s
    assign load_over = load_lhs >= 20'(s_eff) * 20'(LOAD_LIMIT + 1);

    // advance (i + step) mod s goes through the remainder unit
    logic [13:0] adv_raw;
    assign adv_raw = 14'(i_reg) + 14'(kstep);
    assign kstep = step_reg;
    assign adv_sum = adv_raw;
    assign adv_mod = AW'(m_rem);

    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg.ready = 1'b1;
    assign resp.valid = out_valid_reg;
    assign resp.status = out_reg.status;
    assign resp.value_out = out_reg.value_out;

    // step of the blocking key
    logic [5:0] bstep_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == (AW+1)'(SLOTS - 1)) state_next = S_IDLE;
            S_IDLE:  if (req.valid && req.ready) state_next = S_HASH;
            S_HASH:  state_next = S_HMOD;
            S_HMOD:  if (m_done) state_next = S_STEP;
            S_STEP:  state_next = S_SRD;
            S_SRD:   state_next = S_SCHK;
            S_SCHK:
            begin
                if (nvis_reg >= s_eff || !rvalid) state_next =
                    (rtype_reg == REQ_GET) ? S_OUT : S_LOAD;
                else if (rkey == key_reg) state_next =
                    (rtype_reg == REQ_GET) ? S_OUT : S_WRITE;
                else state_next = S_SADV;
            end
            S_SADV:  if (m_done) state_next = S_SRD;
            S_LOAD:  state_next = load_over ? S_OUT : S_IRD;
            S_IRD:   state_next = S_ICHK;
            S_ICHK:
            begin
                if (nvis_reg >= s_eff) state_next = S_OUT;
                else if (!rvalid) state_next = S_WRITE;
                else state_next = S_NRD;
            end
            S_NRD:   if (m_done) state_next = S_NCHK;
            S_NCHK:  state_next = S_CRD;
            S_CRD:   if (m_done) state_next = S_CCHK;
            S_CCHK:  state_next = S_IADV;
            S_IADV:  state_next = move_reg ? S_WRITE : S_IRD;
            S_WRITE: state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // registers used in brent walk
    logic nvalid_reg, found_reg, move_reg;

    always_comb
    begin
        we = 1'b0;
        vwe = 1'b0;
        wvalid = 1'b1;
        addr = i_reg;
        wkey = key_reg;
        wval = val_reg;
        m_start = 1'b0;
        m_num = 32'(adv_sum);
        m_den = s_eff;
        unique case (state_reg)
            S_CLEAR:
            begin
                vwe = 1'b1;
                wvalid = 1'b0;
                addr = clr_reg[AW-1:0];
            end
            S_HASH:
            begin
                m_start = 1'b1;
                m_num = mag;
            end
            S_SCHK:  if (state_next == S_SADV) m_start = 1'b1;
            S_ICHK:  if (state_next == S_NRD) m_start = 1'b1;
            S_NRD:   if (m_done) addr = adv_mod;
            S_NCHK:
            begin
                m_start = 1'b1;
                m_num = 32'(14'(i_reg) + 14'(bstep_reg));
            end
            S_CRD:   if (m_done) addr = adv_mod;
            S_WRITE:
            begin
                we = 1'b1;
                vwe = 1'b1;
            end
            S_IADV:
            begin
                if (move_reg)
                begin
                    we = 1'b1;
                    vwe = 1'b1;
                    addr = col_reg;
                    wkey = bkey_reg;
                    wval = bval_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            tsize_reg <= SW'(53);
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (cfg.valid && cfg.ready) tsize_reg <= cfg.data;
            if (resp.valid && resp.ready) out_valid_reg <= 1'b0;
            if (state_reg == S_OUT) out_valid_reg <= 1'b1;
            if (state_reg == S_WRITE && !found_reg) cnt_reg <= cnt_reg + 13'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    rtype_reg <= req.req_type;
                    key_reg <= req.key;
                    val_reg <= req.value;
                    found_reg <= 1'b0;
                    move_reg <= 1'b0;
                    out_reg <= '{status: ST_MISS, value_out: '0};
                end
            end
            S_HASH:  mprod_reg <= 48'(key_reg) * 48'(RECIP37);
            S_HMOD:
            begin
                if (m_done)
                begin
                    home_reg <= AW'(m_rem);
                    i_reg <= AW'(m_rem);
                end
            end
            S_STEP:
            begin
                step_reg <= step_of(key_reg, mprod_reg);
                nvis_reg <= '0;
            end
            S_SCHK:
            begin
                nvis_reg <= nvis_reg + 13'd1;
                if (nvis_reg < s_eff && rvalid && rkey == key_reg)
                begin
                    found_reg <= 1'b1;
                    if (rtype_reg == REQ_GET)
                        out_reg <= '{status: ST_FOUND, value_out: rval};
                    else
                        out_reg <= '{status: ST_UPDATED, value_out: '0};
                end
            end
            S_SADV:  if (m_done) i_reg <= adv_mod;
            S_LOAD:
            begin
                i_reg <= home_reg;
                nvis_reg <= '0;
            end
            S_ICHK:
            begin
                bkey_reg <= rkey;
                bval_reg <= rval;
                if (nvis_reg < s_eff && !rvalid)
                    out_reg <= '{status: ST_INSERTED, value_out: '0};
            end
            S_NRD:
            begin
                // the product is registered in mprod_reg; the step comes from that registered product
                mprod_reg <= 48'(bkey_reg) * 48'(RECIP37);
                bstep_reg <= step_of(bkey_reg, mprod_reg);
                if (m_done) nxt_reg <= adv_mod;
            end
            S_NCHK:  nvalid_reg <= rvalid;
            S_CRD:   if (m_done) col_reg <= adv_mod;
            S_CCHK:  move_reg <= nvalid_reg && !rvalid;
            S_IADV:
            begin
                nvis_reg <= nvis_reg + 13'd1;
                // blocking entry moved: new key takes slot i
                if (move_reg)
                    out_reg <= '{status: ST_INSERTED, value_out: '0};
                else
                    i_reg <= nxt_reg;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== verif/bdh_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bdh_checker
    import bdh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bdh_req_if        req,
    bdh_resp_if       resp,
    bdh_cfg_if        cfg,
    output int        mismatches,
    output int        pending
);

    logic [KW-1:0] tbl_key [SLOTS];
    logic [VW-1:0] tbl_value [SLOTS];
    bit            tbl_valid [SLOTS];
    logic [12:0]   occupied;
    logic [SW-1:0] size_reg;
    resp_t         expected_q [$];

    function automatic int unsigned slots_in_use();
        int unsigned s;
        s = size_reg;
        if (s > SLOTS) s = SLOTS;
        if (s == 0) s = 1;
        return s;
    endfunction

    function automatic int unsigned home_of(logic [KW-1:0] k, int unsigned s);
        logic [31:0] p;
        p = 32'(k) * 32'd3141;
        if (p[31]) p = -p;
        return p % s;
    endfunction

    function automatic int unsigned next_of(int unsigned i, logic [KW-1:0] k,
                                            int unsigned s);
        return (i + 1 + 32'(k) % 37) % s;
    endfunction

    // one request against the shadow table, updating it like the block does
    function automatic resp_t lookup_or_store(logic rt, logic [KW-1:0] k,
                                              logic [VW-1:0] v);
        int unsigned s, i, n, at, nxt, col;
        bit hit, placed;
        resp_t r;
        s = slots_in_use();
        hit = 0;
        at = 0;
        placed = 0;
        r.status = ST_MISS;
        r.value_out = '0;
        i = home_of(k, s);
        for (n = 0; n < s; n++)
        begin
            if (!tbl_valid[i]) break;
            if (tbl_key[i] == k)
            begin
                hit = 1;
                at = i;
                break;
            end
            i = next_of(i, k, s);
        end
        if (rt == REQ_GET)
        begin
            if (hit)
            begin
                r.status = ST_FOUND;
                r.value_out = tbl_value[at];
            end
            return r;
        end
        if (hit)
        begin
            tbl_value[at] = v;
            r.status = ST_UPDATED;
            return r;
        end
        if ((100 * int'(occupied)) / s > LOAD_LIMIT) return r;
        i = home_of(k, s);
        for (n = 0; n < s; n++)
        begin
            if (!tbl_valid[i])
            begin
                placed = 1;
                break;
            end
            nxt = next_of(i, k, s);
            col = next_of(i, tbl_key[i], s);
            // brent move: blocker steps aside into its own empty next slot
            if (tbl_valid[nxt] && !tbl_valid[col])
            begin
                tbl_key[col] = tbl_key[i];
                tbl_value[col] = tbl_value[i];
                tbl_valid[col] = 1;
                placed = 1;
                break;
            end
            i = nxt;
        end
        if (!placed) return r;
        tbl_key[i] = k;
        tbl_value[i] = v;
        tbl_valid[i] = 1;
        occupied = occupied + 13'd1;
        r.status = ST_INSERTED;
        return r;
    endfunction

    initial
    begin
        mismatches = 0;
        occupied = '0;
        size_reg = SW'(53);
        for (int j = 0; j < SLOTS; j++) tbl_valid[j] = 0;
    end

    assign pending = expected_q.size();

    always @(posedge clk)
    begin
        resp_t want;
        if (rst_n)
        begin
            if (resp.valid && resp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response status=%0d value=%h",
                                 resp.status, resp.value_out);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.status !== resp.status || want.value_out !== resp.value_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected status=%0d value=%h, got status=%0d value=%h",
                                     want.status, want.value_out, resp.status, resp.value_out);
                    end
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(lookup_or_store(req.req_type, req.key, req.value));
            if (cfg.valid && cfg.ready)
                size_reg = cfg.data;
        end
    end

endmodule
`default_nettype wire

// ===== verif/brent_double_hash_table_top_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module brent_double_hash_table_top_tb;
    import bdh_pkg::*;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;

    // idle percentages for the sender and the receiver
    int   tx_idle;
    int   rx_idle;
    bit   hold_go;
    bit   hold_done;

    logic [KW-1:0] key_pool [96];

    bdh_req_if  req_ch ();
    bdh_resp_if resp_ch ();
    bdh_cfg_if  cfg_ch ();

    brent_double_hash_table_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .resp  (resp_ch),
        .cfg   (cfg_ch)
    );

    bdh_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .resp       (resp_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // run limit, far above the slowest legal run including the clearing pass
    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 4000000)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    initial
    begin
        resp_ch.ready = 0;
        hold_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                resp_ch.ready <= 0;
                repeat (3000) @(negedge clk);
                hold_done = 1;
            end
            else
                resp_ch.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // one request transfer, with random idle cycles ahead of it
    task automatic send_req(logic rt, logic [KW-1:0] k, logic [VW-1:0] v);
        while ($urandom_range(99) < tx_idle)
        begin
            req_ch.valid <= 0;
            @(negedge clk);
        end
        req_ch.valid    <= 1;
        req_ch.req_type <= rt;
        req_ch.key      <= k;
        req_ch.value    <= v;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    // table size write, only once every response is back
    task automatic set_size(logic [SW-1:0] sz);
        req_ch.valid <= 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        cfg_ch.valid <= 1;
        cfg_ch.data  <= sz;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 0;
    endtask

    // mostly keys from a small pool so sets hit and gets find something
    task automatic random_reqs(int count);
        logic rt;
        logic [KW-1:0] k;
        for (int n = 0; n < count; n++)
        begin
            rt = ($urandom_range(99) < 55) ? REQ_SET : REQ_GET;
            if ($urandom_range(3) == 0)
                k = KW'($urandom());
            else
                k = key_pool[$urandom_range(95)];
            send_req(rt, k, $urandom());
        end
    endtask

    initial
    begin
        rst_n = 0;
        tx_idle = 27;
        rx_idle = 58;
        hold_go = 0;
        req_ch.valid = 0;
        req_ch.req_type = REQ_SET;
        req_ch.key = '0;
        req_ch.value = '0;
        cfg_ch.valid = 0;
        cfg_ch.data = '0;
        for (int j = 0; j < 96; j++) key_pool[j] = KW'($urandom());
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        set_size(SW'(53));
        // directed: field extremes, update in place, miss on empty table
        send_req(REQ_GET, 24'h000005, 32'h0);
        send_req(REQ_SET, 24'h000000, 32'h00000000);
        send_req(REQ_SET, 24'hffffff, 32'hffffffff);
        send_req(REQ_GET, 24'h000000, 32'hffffffff);
        send_req(REQ_GET, 24'hffffff, 32'h0);
        send_req(REQ_SET, 24'h000000, 32'h12345678);
        send_req(REQ_GET, 24'h000000, 32'h0);
        send_req(REQ_SET, 24'hffffff, 32'h0);
        send_req(REQ_GET, 24'hffffff, 32'h0);
        send_req(REQ_GET, 24'h555555, 32'haaaaaaaa);
        send_req(REQ_SET, 24'h555555, 32'haaaaaaaa);
        send_req(REQ_SET, 24'haaaaaa, 32'h55555555);
        send_req(REQ_GET, 24'haaaaaa, 32'h0);
        // same step, same home slot: forces collisions
        for (int j = 0; j < 8; j++)
            send_req(REQ_SET, KW'(j * 37 * 53), $urandom());
        // filling a 53-slot table also runs into the load limit
        random_reqs(150);

        // size zero acts as one slot, walks run out at once
        set_size(SW'(0));
        random_reqs(30);

        // largest size the register holds, just under capacity
        set_size(SW'(4095));
        random_reqs(120);

        tx_idle = 58;
        rx_idle = 27;
        set_size(SW'(4093));
        random_reqs(200);

        // a two-slot table
        set_size(SW'(2));
        random_reqs(60);

        tx_idle = 0;
        rx_idle = 0;
        set_size(SW'(53));
        hold_go = 1;
        random_reqs(150);
        set_size(SW'(101));
        random_reqs(100);

        req_ch.valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
